/* rtl/epu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package epu_pkg;

	// fixed-point constants, Q16.16 degrees unless noted
	localparam int VECTOR_FRAC_BITS_DEF = 14;
	localparam int CORDIC_STEPS         = 16;
	localparam int CORDIC_IW            = $clog2(CORDIC_STEPS);
	localparam int CORDIC_XW            = 34;   // Q30 with headroom
	localparam int ANGLE_W              = 27;
	localparam int MUL_W                = 32;

	localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANGLE_W-1:0]   DEG_90      = 27'sd5898240;
	localparam logic signed [ANGLE_W-1:0]   DEG_180     = 27'sd11796480;
	localparam logic signed [ANGLE_W-1:0]   DEG_360     = 27'sd23592960;
	localparam logic signed [63:0]          PITCH_LIMIT = 64'sd5891686;
	localparam logic signed [63:0]          YAW_LIMIT   = 64'sd23586406;

	localparam logic [15:0] SPEED_RST = 16'd256;
	localparam logic [15:0] SENS_RST  = 16'd6554;

	localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
		27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
		27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
		27'sd917,     27'sd458,     27'sd229,    27'sd115
	};

	typedef enum logic [2:0] {
		KIND_MOVE   = 3'd0,
		KIND_LOOK   = 3'd1,
		KIND_POSE   = 3'd2,
		KIND_POS    = 3'd3,
		KIND_INVERT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		DIR_FWD   = 3'd0,
		DIR_BACK  = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_UP    = 3'd4,
		DIR_DOWN  = 3'd5
	} dir_t;

	typedef enum logic {
		REG_SPEED = 1'b0,
		REG_SENS  = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MV_VEL,
		ST_MV_LD,
		ST_MV_MUL,
		ST_MV_ACC,
		ST_LK_X,
		ST_LK_Y,
		ST_LK_P,
		ST_CR_YAW,
		ST_CR_YAW_W,
		ST_CR_PIT,
		ST_CR_PIT_W,
		ST_VP0,
		ST_VP1,
		ST_VP2,
		ST_VP3,
		ST_VP4,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CPH_IDLE,
		CPH_FOLD,
		CPH_ITER,
		CPH_OUT
	} cph_t;

	// request/response between the sequencer and the CORDIC
	typedef struct packed {
		logic                       start;
		logic signed [ANGLE_W-1:0]  angle;
	} cordic_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [MUL_W-1:0]    sn;
		logic signed [MUL_W-1:0]    cs;
	} cordic_rsp_t;

endpackage

`default_nettype wire

/* rtl/euler_camera_pose_update.sv */
`timescale 1ns / 1ps
`default_nettype none

// First-person camera pose unit. It holds position (Q16.16), yaw and pitch
// (Q16.16 degrees) and the front, right and up unit vectors (signed
// Q1.VECTOR_FRAC_BITS; the ports carry the low 16 bits). One item is taken
// at a time, and in_stall stays high while it is worked on. A move item uses
// one registered multiplier to form the velocity and then one product per
// axis. A look or set-pose item makes two passes of the shared 16-step
// CORDIC (sine and cosine of yaw then pitch) and then four products through
// the same multiplier for the vectors. Set position, invert pitch and
// unknown kinds go from idle straight to the done state.
// Invert pitch leaves the vectors as they were. A finished item waits in the
// output register, so the next item may be taken while it is unread.
// Configuration writes take effect at once and belong to idle periods.
module euler_camera_pose_update #(
	parameter int VECTOR_FRAC_BITS = epu_pkg::VECTOR_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic               wr_index,
	input  wire logic [15:0]        wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [2:0]         direction,
	input  wire logic [19:0]        delta_time,
	input  wire logic signed [31:0] x_offset,
	input  wire logic signed [31:0] y_offset,
	input  wire logic signed [31:0] new_x,
	input  wire logic signed [31:0] new_y,
	input  wire logic signed [31:0] new_z,
	input  wire logic signed [25:0] new_yaw,
	input  wire logic signed [23:0] new_pitch,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [15:0]      front_x,
	output logic signed [15:0]      front_y,
	output logic signed [15:0]      front_z,
	output logic signed [15:0]      up_x,
	output logic signed [15:0]      up_y,
	output logic signed [15:0]      up_z,
	output logic signed [25:0]      yaw,
	output logic signed [23:0]      pitch
);
	import epu_pkg::*;

	localparam int VW   = VECTOR_FRAC_BITS + 2;
	localparam int SH30 = 30 - VECTOR_FRAC_BITS;
	localparam int SH60 = 60 - VECTOR_FRAC_BITS;
	localparam logic signed [63:0] H30  = (64'sd1 <<< SH30) >>> 1;
	localparam logic signed [63:0] H60  = (64'sd1 <<< SH60) >>> 1;
	localparam logic signed [63:0] HV   = (64'sd1 <<< VECTOR_FRAC_BITS) >>> 1;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< VECTOR_FRAC_BITS;
	localparam logic signed [VW-1:0] V_ONE = VW'(ONE);

	// round half up to the vector format, then clamp to +-1
	function automatic logic signed [VW-1:0] to_unit(input logic signed [63:0] v,
			input logic q60);
		logic signed [63:0] r;
		begin
			r = q60 ? ((v + H60) >>> SH60) : ((v + H30) >>> SH30);
			if (r > ONE)
				r = ONE;
			if (r < -ONE)
				r = -ONE;
			return VW'(r);
		end
	endfunction

	state_t state_q, state_d;

	logic [15:0]              speed_q, sens_q;
	logic signed [31:0]       pos_q [3];
	logic signed [25:0]       yaw_q;
	logic signed [23:0]       pitch_q;
	logic signed [VW-1:0]     front_q [3];
	logic signed [VW-1:0]     right_q [3];
	logic signed [VW-1:0]     up_q [3];

	logic [2:0]               dir_q;
	logic [19:0]              dt_q;
	logic signed [31:0]       xoff_q, yoff_q;
	logic [27:0]              vel_q;
	logic [1:0]               k_q;
	logic signed [MUL_W-1:0]  sy_q, cy_q, sp_q, cp_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	cordic_req_t               cor_req;
	cordic_rsp_t               cor_rsp;

	logic                     in_acc;
	logic                     out_load;
	logic                     dir_ok;
	logic                     dir_sub;
	logic signed [VW-1:0]     vsel;
	logic signed [63:0]       step_d;
	logic signed [33:0]       pos_sum;
	logic signed [31:0]       pos_sat;
	logic signed [63:0]       ang_d, ang_n;
	logic                     s_neg;

	logic                     out_valid_q;
	logic signed [31:0]       opos_q [3];
	logic signed [15:0]       ofront_q [3];
	logic signed [15:0]       oup_q [3];
	logic signed [25:0]       oyaw_q;
	logic signed [23:0]       opitch_q;

	epu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	epu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	assign in_acc  = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign dir_ok  = (dir_q == DIR_FWD) || (dir_q == DIR_BACK) || (dir_q == DIR_LEFT) ||
			(dir_q == DIR_RIGHT) || (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
	assign dir_sub = (dir_q == DIR_BACK) || (dir_q == DIR_LEFT) || (dir_q == DIR_DOWN);
	assign s_neg   = cp_q < 0;

	always_comb begin
		if (dir_q == DIR_FWD || dir_q == DIR_BACK)
			vsel = front_q[k_q];
		else if (dir_q == DIR_LEFT || dir_q == DIR_RIGHT)
			vsel = right_q[k_q];
		else
			vsel = up_q[k_q];
	end

	// move step: round the product back to Q16.16 and saturate the sum
	always_comb begin
		step_d  = (mul_p + HV) >>> VECTOR_FRAC_BITS;
		pos_sum = dir_sub ? (34'(pos_q[k_q]) - 34'(step_d)) : (34'(pos_q[k_q]) + 34'(step_d));
		if (pos_sum > 34'sd2147483647)
			pos_sat = 32'sh7fffffff;
		else if (pos_sum < -34'sd2147483648)
			pos_sat = 32'sh80000000;
		else
			pos_sat = 32'(pos_sum);
	end

	// scaled look offset, rounded half up to Q16.16
	assign ang_d = (mul_p + 64'sd32768) >>> 16;
	assign ang_n = (state_q == ST_LK_Y) ? (64'(yaw_q) + ang_d) : (64'(pitch_q) + ang_d);

	// sequencer
	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		mul_a         = '0;
		mul_b         = '0;
		cor_req.start = 1'b0;
		cor_req.angle = ANGLE_W'(yaw_q);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (kind)
						KIND_MOVE: state_d = ST_MV_VEL;
						KIND_LOOK: state_d = ST_LK_X;
						KIND_POSE: state_d = ST_CR_YAW;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_MV_VEL: begin
				mul_a   = MUL_W'($signed({1'b0, speed_q}));
				mul_b   = MUL_W'($signed({1'b0, dt_q}));
				state_d = dir_ok ? ST_MV_LD : ST_DONE;
			end
			ST_MV_LD: state_d = ST_MV_MUL;
			ST_MV_MUL: begin
				mul_a   = MUL_W'($signed({1'b0, vel_q}));
				mul_b   = MUL_W'(vsel);
				state_d = ST_MV_ACC;
			end
			ST_MV_ACC: state_d = (k_q == 2'd2) ? ST_DONE : ST_MV_MUL;
			ST_LK_X: begin
				mul_a   = xoff_q;
				mul_b   = MUL_W'($signed({1'b0, sens_q}));
				state_d = ST_LK_Y;
			end
			ST_LK_Y: begin
				mul_a   = yoff_q;
				mul_b   = MUL_W'($signed({1'b0, sens_q}));
				state_d = ST_LK_P;
			end
			ST_LK_P: state_d = ST_CR_YAW;
			ST_CR_YAW: begin
				cor_req.start = 1'b1;
				state_d       = ST_CR_YAW_W;
			end
			ST_CR_YAW_W: begin
				if (cor_rsp.done)
					state_d = ST_CR_PIT;
			end
			ST_CR_PIT: begin
				cor_req.start = 1'b1;
				cor_req.angle = ANGLE_W'(pitch_q);
				state_d       = ST_CR_PIT_W;
			end
			ST_CR_PIT_W: begin
				if (cor_rsp.done)
					state_d = ST_VP0;
			end
			ST_VP0: begin
				mul_a   = cy_q;
				mul_b   = cp_q;
				state_d = ST_VP1;
			end
			ST_VP1: begin
				mul_a   = sy_q;
				mul_b   = cp_q;
				state_d = ST_VP2;
			end
			ST_VP2: begin
				mul_a   = cy_q;
				mul_b   = sp_q;
				state_d = ST_VP3;
			end
			ST_VP3: begin
				mul_a   = sy_q;
				mul_b   = sp_q;
				state_d = ST_VP4;
			end
			ST_VP4: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= SPEED_RST;
			sens_q     <= SENS_RST;
			pos_q      <= '{3{32'sd0}};
			yaw_q      <= '0;
			pitch_q    <= '0;
			front_q    <= '{V_ONE, '0, '0};
			right_q    <= '{'0, '0, V_ONE};
			up_q       <= '{'0, V_ONE, '0};
			k_q        <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_SPEED: speed_q <= wr_data;
					REG_SENS:  sens_q  <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_acc) begin
						if (kind == KIND_POSE || kind == KIND_POS) begin
							pos_q[0] <= new_x;
							pos_q[1] <= new_y;
							pos_q[2] <= new_z;
						end
						if (kind == KIND_POSE) begin
							yaw_q   <= new_yaw;
							pitch_q <= new_pitch;
						end
						if (kind == KIND_INVERT)
							pitch_q <= (pitch_q == 24'sh800000) ? 24'sh7fffff : -pitch_q;
					end
				end
				ST_MV_ACC: begin
					pos_q[k_q] <= pos_sat;
					k_q        <= k_q + 1'b1;
				end
				ST_LK_Y: begin
					// yaw snaps to zero past a full turn
					if (ang_n > YAW_LIMIT || ang_n < -YAW_LIMIT)
						yaw_q <= '0;
					else
						yaw_q <= 26'(ang_n);
				end
				ST_LK_P: begin
					if (ang_n > PITCH_LIMIT)
						pitch_q <= 24'(PITCH_LIMIT);
					else if (ang_n < -PITCH_LIMIT)
						pitch_q <= 24'(-PITCH_LIMIT);
					else
						pitch_q <= 24'(ang_n);
				end
				ST_VP1: front_q[0] <= to_unit(mul_p, 1'b1);
				ST_VP2: front_q[2] <= to_unit(mul_p, 1'b1);
				ST_VP3: up_q[0] <= to_unit(s_neg ? mul_p : -mul_p, 1'b1);
				ST_VP4: begin
					// right and up flip when cos(pitch) is negative
					up_q[2]    <= to_unit(s_neg ? mul_p : -mul_p, 1'b1);
					front_q[1] <= to_unit(64'(sp_q), 1'b0);
					up_q[1]    <= to_unit(s_neg ? -64'(cp_q) : 64'(cp_q), 1'b0);
					right_q[0] <= to_unit(s_neg ? 64'(sy_q) : -64'(sy_q), 1'b0);
					right_q[1] <= '0;
					right_q[2] <= to_unit(s_neg ? -64'(cy_q) : 64'(cy_q), 1'b0);
				end
				default: ;
			endcase
		end
	end

	// item operands and trig results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dir_q  <= direction;
			dt_q   <= delta_time;
			xoff_q <= x_offset;
			yoff_q <= y_offset;
		end
		if (state_q == ST_MV_LD)
			vel_q <= 28'((mul_p + 64'sd128) >>> 8);
		if (state_q == ST_CR_YAW_W && cor_rsp.done) begin
			sy_q <= cor_rsp.sn;
			cy_q <= cor_rsp.cs;
		end
		if (state_q == ST_CR_PIT_W && cor_rsp.done) begin
			sp_q <= cor_rsp.sn;
			cp_q <= cor_rsp.cs;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++) begin
				opos_q[i]   <= pos_q[i];
				ofront_q[i] <= 16'(front_q[i]);
				oup_q[i]    <= 16'(up_q[i]);
			end
			oyaw_q   <= yaw_q;
			opitch_q <= pitch_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = opos_q[0];
	assign pos_y     = opos_q[1];
	assign pos_z     = opos_q[2];
	assign front_x   = ofront_q[0];
	assign front_y   = ofront_q[1];
	assign front_z   = ofront_q[2];
	assign up_x      = oup_q[0];
	assign up_y      = oup_q[1];
	assign up_z      = oup_q[2];
	assign yaw       = oyaw_q;
	assign pitch     = opitch_q;

	// every accepted item leaves idle
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("accepted item did not start");

	// CORDIC finishes only while the sequencer waits for it
	a_cor_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_rsp.done |-> (state_q == ST_CR_YAW_W || state_q == ST_CR_PIT_W))
		else $error("CORDIC result with nobody waiting");

	// front x and up y stay within unit range
	a_front_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(front_q[0] <= V_ONE) && (front_q[0] >= -V_ONE) &&
		(up_q[1] <= V_ONE) && (up_q[1] >= -V_ONE))
		else $error("vector component out of range");

	// a result is only loaded when the previous one has gone or goes now
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten");

endmodule

`default_nettype wire

/* rtl/epu_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module epu_mul (
	input  wire logic                               clk,
	input  wire logic signed [epu_pkg::MUL_W-1:0]   a,
	input  wire logic signed [epu_pkg::MUL_W-1:0]   b,
	output logic signed [2*epu_pkg::MUL_W-1:0]      p
);
	import epu_pkg::*;

	logic signed [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

`default_nettype wire

/* rtl/epu_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module epu_cordic (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire epu_pkg::cordic_req_t   req,
	output epu_pkg::cordic_rsp_t        rsp
);
	import epu_pkg::*;

	cph_t                       ph_q;
	logic [CORDIC_IW-1:0]       i_q;
	logic signed [ANGLE_W-1:0]  a_q;
	logic signed [ANGLE_W-1:0]  z_q;
	logic signed [CORDIC_XW-1:0] x_q, y_q;
	logic                       neg_q;
	logic                       done_q;
	logic signed [MUL_W-1:0]    sn_q, cs_q;
	logic signed [ANGLE_W-1:0]  a_red;
	logic signed [CORDIC_XW-1:0] dx, dy;

	// one wrap into [-180,180) covers the widest angle field
	always_comb begin
		a_red = req.angle;
		if (req.angle >= DEG_180)
			a_red = req.angle - DEG_360;
		else if (req.angle < -DEG_180)
			a_red = req.angle + DEG_360;
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= CPH_IDLE;
			i_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				CPH_IDLE: begin
					if (req.start)
						ph_q <= CPH_FOLD;
				end
				CPH_FOLD: begin
					ph_q <= CPH_ITER;
					i_q  <= '0;
				end
				CPH_ITER: begin
					i_q <= i_q + 1'b1;
					if (i_q == CORDIC_IW'(CORDIC_STEPS - 1))
						ph_q <= CPH_OUT;
				end
				CPH_OUT: begin
					ph_q   <= CPH_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= CPH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			CPH_IDLE: begin
				if (req.start)
					a_q <= a_red;
			end
			CPH_FOLD: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				if (a_q > DEG_90) begin
					z_q   <= a_q - DEG_180;
					neg_q <= 1'b1;
				end else if (a_q < -DEG_90) begin
					z_q   <= a_q + DEG_180;
					neg_q <= 1'b1;
				end else begin
					z_q   <= a_q;
					neg_q <= 1'b0;
				end
			end
			CPH_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ATAN_TAB[i_q];
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ATAN_TAB[i_q];
				end
			end
			CPH_OUT: begin
				sn_q <= MUL_W'(neg_q ? -y_q : y_q);
				cs_q <= MUL_W'(neg_q ? -x_q : x_q);
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sn   = sn_q;
	assign rsp.cs   = cs_q;

endmodule

`default_nettype wire

/* tb/tb_euler_camera_pose_update.sv */
`timescale 1ns / 1ps

module tb_euler_camera_pose_update;
	import epu_pkg::*;

	localparam int  FRAC       = 14;
	localparam int  GAP_MAX    = 6;
	localparam int  DRAIN_CYC  = 80;    // covers the slowest item
	localparam longint LIMIT   = 3000000;

	// one input item, one field per port
	typedef struct {
		logic [2:0]         k;
		logic [2:0]         d;
		logic [19:0]        dt;
		logic signed [31:0] xo;
		logic signed [31:0] yo;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [25:0] nyaw;
		logic signed [23:0] npitch;
	} cam_item_t;

	// one reported pose
	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] fx, fy, fz;
		logic signed [15:0] ux, uy, uz;
		logic signed [25:0] yw;
		logic signed [23:0] pt;
	} pose_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic               wr_index;
	logic [15:0]        wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic [2:0]         direction;
	logic [19:0]        delta_time;
	logic signed [31:0] x_offset, y_offset, new_x, new_y, new_z;
	logic signed [25:0] new_yaw;
	logic signed [23:0] new_pitch;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] front_x, front_y, front_z, up_x, up_y, up_z;
	logic signed [25:0] yaw;
	logic signed [23:0] pitch;

	euler_camera_pose_update DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .direction(direction), .delta_time(delta_time),
		.x_offset(x_offset), .y_offset(y_offset),
		.new_x(new_x), .new_y(new_y), .new_z(new_z),
		.new_yaw(new_yaw), .new_pitch(new_pitch),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.front_x(front_x), .front_y(front_y), .front_z(front_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.yaw(yaw), .pitch(pitch)
	);

	// predicted camera state, mirrored from the block
	longint cam_pos [3];
	longint cam_yaw, cam_pitch;
	longint cam_front [3];
	longint cam_right [3];
	longint cam_up [3];
	longint cam_speed, cam_sens;

	pose_t  pending_poses [$];
	int     fail_count;
	longint cycle_count;
	int     send_idle_pct;   // chance of a gap before each item
	int     recv_stall_pct;  // chance of stalling the result side
	int     hold_left;       // long receiver hold-off, counted down below

	localparam longint ATAN_DEG [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint rnd_shr(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q30 / Q60 down to unit vector fixed point, clamped to +-1
	function automatic longint unit_q(longint v, int frac);
		longint one, r;
		one = 64'sd1 <<< FRAC;
		r = rnd_shr(v, frac - FRAC);
		if (r > one)
			r = one;
		if (r < -one)
			r = -one;
		return r;
	endfunction

	// degree CORDIC with range fold
	task automatic trig_deg(input longint a, output longint sn, output longint cs);
		longint x, y, z, dx, dy;
		bit neg;
		x = 652032874;
		y = 0;
		neg = 1'b0;
		while (a >= 11796480)
			a -= 23592960;
		while (a < -11796480)
			a += 23592960;
		if (a > 5898240) begin
			a -= 11796480;
			neg = 1'b1;
		end else if (a < -5898240) begin
			a += 11796480;
			neg = 1'b1;
		end
		z = a;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_DEG[i];
			end else begin
				x += dx; y -= dy; z += ATAN_DEG[i];
			end
		end
		sn = neg ? -y : y;
		cs = neg ? -x : x;
	endtask

	task automatic rebuild_basis();
		longint sy, cy, sp, cp, s;
		trig_deg(cam_yaw, sy, cy);
		trig_deg(cam_pitch, sp, cp);
		s = (cp < 0) ? -1 : 1;
		cam_front[0] = unit_q(cy * cp, 60);
		cam_front[1] = unit_q(sp, 30);
		cam_front[2] = unit_q(sy * cp, 60);
		cam_right[0] = unit_q(-s * sy, 30);
		cam_right[1] = 0;
		cam_right[2] = unit_q(s * cy, 30);
		cam_up[0] = unit_q(-s * (cy * sp), 60);
		cam_up[1] = unit_q(s * cp, 30);
		cam_up[2] = unit_q(-s * (sy * sp), 60);
	endtask

	task automatic cam_reset();
		for (int i = 0; i < 3; i++)
			cam_pos[i] = 0;
		cam_yaw = 0;
		cam_pitch = 0;
		cam_front = '{64'sd16384, 0, 0};
		cam_right = '{0, 0, 64'sd16384};
		cam_up    = '{0, 64'sd16384, 0};
		cam_speed = 256;
		cam_sens  = 6554;
	endtask

	// advance the predicted state by one item and queue the pose it reports
	task automatic predict_pose(input cam_item_t it);
		longint vel, step, dxl, dyl, nyw, npt;
		bit sub;
		pose_t p;
		if (it.k == KIND_MOVE && it.d <= DIR_DOWN) begin
			vel = (cam_speed * longint'(it.dt) + 128) >>> 8;
			sub = (it.d == DIR_BACK || it.d == DIR_LEFT || it.d == DIR_DOWN);
			for (int i = 0; i < 3; i++) begin
				if (it.d <= DIR_BACK)
					step = rnd_shr(vel * cam_front[i], FRAC);
				else if (it.d <= DIR_RIGHT)
					step = rnd_shr(vel * cam_right[i], FRAC);
				else
					step = rnd_shr(vel * cam_up[i], FRAC);
				cam_pos[i] = sat_s32(cam_pos[i] + (sub ? -step : step));
			end
		end else if (it.k == KIND_LOOK) begin
			dxl = rnd_shr(longint'(it.xo) * cam_sens, 16);
			dyl = rnd_shr(longint'(it.yo) * cam_sens, 16);
			nyw = cam_yaw + dxl;
			npt = cam_pitch + dyl;
			if (npt > 5891686)
				npt = 5891686;
			if (npt < -5891686)
				npt = -5891686;
			if (nyw > 23586406 || nyw < -23586406)
				nyw = 0;
			cam_yaw = nyw;
			cam_pitch = npt;
			rebuild_basis();
		end else if (it.k == KIND_POSE || it.k == KIND_POS) begin
			cam_pos[0] = it.nx;
			cam_pos[1] = it.ny;
			cam_pos[2] = it.nz;
			if (it.k == KIND_POSE) begin
				cam_yaw = it.nyaw;
				cam_pitch = it.npitch;
				rebuild_basis();
			end
		end else if (it.k == KIND_INVERT) begin
			npt = -cam_pitch;
			if (npt > 8388607)
				npt = 8388607;
			cam_pitch = npt;
		end
		p.px = cam_pos[0][31:0];
		p.py = cam_pos[1][31:0];
		p.pz = cam_pos[2][31:0];
		p.fx = cam_front[0][15:0];
		p.fy = cam_front[1][15:0];
		p.fz = cam_front[2][15:0];
		p.ux = cam_up[0][15:0];
		p.uy = cam_up[1][15:0];
		p.uz = cam_up[2][15:0];
		p.yw = cam_yaw[25:0];
		p.pt = cam_pitch[23:0];
		pending_poses.push_back(p);
	endtask

	task automatic cmp_field(input string nm, input longint e, input longint a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
			fail_count++;
		end
	endtask

	// result side: check each accepted pose, stall as the phase asks
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected pose, pos_x %0d", $time, pos_x);
				fail_count++;
			end else begin
				e = pending_poses.pop_front();
				cmp_field("pos_x", e.px, pos_x);
				cmp_field("pos_y", e.py, pos_y);
				cmp_field("pos_z", e.pz, pos_z);
				cmp_field("front_x", e.fx, front_x);
				cmp_field("front_y", e.fy, front_y);
				cmp_field("front_z", e.fz, front_z);
				cmp_field("up_x", e.ux, up_x);
				cmp_field("up_y", e.uy, up_y);
				cmp_field("up_z", e.uz, up_z);
				cmp_field("yaw", e.yw, yaw);
				cmp_field("pitch", e.pt, pitch);
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// offer one item, optionally after a gap, and hold it until accepted
	task automatic send_item(input cam_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(GAP_MAX, 1)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= it.k;
		direction  <= it.d;
		delta_time <= it.dt;
		x_offset   <= it.xo;
		y_offset   <= it.yo;
		new_x      <= it.nx;
		new_y      <= it.ny;
		new_z      <= it.nz;
		new_yaw    <= it.nyaw;
		new_pitch  <= it.npitch;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		predict_pose(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// registers only change once the block has gone quiet
	task automatic set_regs(input logic [15:0] spd, input logic [15:0] sens);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= REG_SPEED;
		wr_data <= spd;
		@(posedge clk);
		wr_index <= REG_SENS;
		wr_data <= sens;
		@(posedge clk);
		wr_en <= 1'b0;
		cam_speed = spd;
		cam_sens = sens;
	endtask

	function automatic cam_item_t blank_item(input logic [2:0] k);
		cam_item_t it;
		it = '{k: k, d: DIR_FWD, dt: '0, xo: '0, yo: '0, nx: '0, ny: '0, nz: '0,
			nyaw: '0, npitch: '0};
		return it;
	endfunction

	function automatic logic signed [31:0] rnd_s32();
		return $urandom;
	endfunction

	// random item: mostly sensible content, some full-range noise
	function automatic cam_item_t rand_item();
		cam_item_t it;
		int sel;
		it = blank_item(KIND_MOVE);
		sel = $urandom_range(99);
		if (sel < 35)
			it.k = KIND_MOVE;
		else if (sel < 63)
			it.k = KIND_LOOK;
		else if (sel < 75)
			it.k = KIND_POSE;
		else if (sel < 83)
			it.k = KIND_POS;
		else if (sel < 93)
			it.k = KIND_INVERT;
		else
			it.k = 3'($urandom_range(7, 5));
		it.d = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		it.dt = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(8192));
		if ($urandom_range(7) == 0) begin
			it.xo = rnd_s32();
			it.yo = rnd_s32();
		end else begin
			it.xo = $signed($urandom_range(2000000)) - 1000000;
			it.yo = $signed($urandom_range(2000000)) - 1000000;
		end
		if ($urandom_range(3) == 0) begin
			it.nx = rnd_s32();
			it.ny = rnd_s32();
			it.nz = rnd_s32();
		end else begin
			it.nx = $signed($urandom_range(2000000)) - 1000000;
			it.ny = $signed($urandom_range(2000000)) - 1000000;
			it.nz = $signed($urandom_range(2000000)) - 1000000;
		end
		if ($urandom_range(9) == 0) begin
			it.nyaw = 26'($urandom);
			it.npitch = 24'($urandom);
		end else begin
			it.nyaw = $signed($urandom_range(47172812)) - 23586406;
			it.npitch = $signed($urandom_range(11783372)) - 5891686;
		end
		return it;
	endfunction

	task automatic run_random(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_item(rand_item());
	endtask

	// field extremes for move, look, set-position and set-pose, every direction
	task automatic test_extremes();
		cam_item_t it;
		for (int d = 0; d < 8; d++) begin
			it = blank_item(KIND_MOVE);
			it.d = 3'(d);
			it.dt = (d % 2) ? 20'hFFFFF : 20'h10000;
			send_item(it);
		end
		it = blank_item(KIND_LOOK);
		it.xo = 32'sh7FFFFFFF;
		it.yo = 32'sh7FFFFFFF;
		send_item(it);
		it.xo = 32'sh80000000;
		it.yo = 32'sh80000000;
		send_item(it);
		it = blank_item(KIND_POS);
		it.nx = 32'sh7FFFFFFF;
		it.ny = 32'sh80000000;
		it.nz = 32'sh7FFFFFFF;
		send_item(it);
		it = blank_item(KIND_POSE);
		it.nyaw = 26'sd23586406;
		it.npitch = -24'sd5891686;
		send_item(it);
		it.nyaw = -26'sd23586406;
		it.npitch = 24'sd5891686;
		send_item(it);
	endtask

	// pitch at exactly +-90, out-of-range pose, invert saturation,
	// unknown kinds, position saturation on move
	task automatic test_special();
		cam_item_t it;
		it = blank_item(KIND_POSE);
		it.npitch = 24'sd5898240;
		it.nyaw = 26'sd1234567;
		send_item(it);
		it.npitch = -24'sd5898240;
		send_item(it);
		it.nyaw = 26'sh2000000;
		it.npitch = 24'sh800000;
		send_item(it);
		send_item(blank_item(KIND_INVERT));
		send_item(blank_item(KIND_INVERT));
		for (int k = 5; k < 8; k++)
			send_item(blank_item(3'(k)));
		it = blank_item(KIND_POSE);
		it.nx = 32'sh7FFFFF00;
		it.ny = 32'sh80000100;
		send_item(it);
		it = blank_item(KIND_MOVE);
		it.d = DIR_FWD;
		it.dt = 20'hFFFFF;
		send_item(it);
		it.d = DIR_DOWN;
		send_item(it);
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		repeat (20) send_item(rand_item());
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_SPEED;
		wr_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_MOVE;
		direction <= DIR_FWD;
		delta_time <= '0;
		x_offset <= '0;
		y_offset <= '0;
		new_x <= '0;
		new_y <= '0;
		new_z <= '0;
		new_yaw <= '0;
		new_pitch <= '0;
		out_stall <= 1'b0;
		cam_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults first, then the register extremes
		test_extremes();
		test_special();
		set_regs(16'hFFFF, 16'hFFFF);
		test_extremes();
		set_regs(16'h0000, 16'h0000);
		test_extremes();
		set_regs(16'd256, 16'd6554);

		run_random(250, 0, 0);
		run_random(250, 58, 0);
		set_regs(16'($urandom), 16'($urandom));
		run_random(250, 0, 58);
		test_backpressure();
		set_regs(16'hFFFF, 16'd65535);
		run_random(150, 21, 21);
		set_regs(16'd256, 16'd6554);
		run_random(200, 21, 21);

		wait_idle();
		if (fail_count == 0 && pending_poses.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
